// ===== hdl/trls_pkg.sv =====
// Shared types, codes and helper functions for the timestamp range log store.
package trls_pkg;

   localparam int TIME_W      = 56;
   localparam int TIME_DIGITS = 14;
   localparam int LOG_ID_W    = 16;
   localparam int GRAN_W      = 3;
   localparam int STATUS_W    = 2;

   // Command codes
   localparam logic CMD_PUT = 1'b0;
   localparam logic CMD_GET = 1'b1;

   // Response status codes
   localparam logic [STATUS_W-1:0] STATUS_STORED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd2;

   // Granularity codes
   localparam logic [GRAN_W-1:0] GRAN_YEAR   = 3'd0;
   localparam logic [GRAN_W-1:0] GRAN_MONTH  = 3'd1;
   localparam logic [GRAN_W-1:0] GRAN_DAY    = 3'd2;
   localparam logic [GRAN_W-1:0] GRAN_HOUR   = 3'd3;
   localparam logic [GRAN_W-1:0] GRAN_MINUTE = 3'd4;

   localparam logic [3:0] FILL_LOW  = 4'd0;
   localparam logic [3:0] FILL_HIGH = 4'd9;

   // Broadcast control for every cell of the chain
   typedef struct packed {
      logic              ins;       // sorted insert of key
      logic              rot;       // rotate occupied cells toward cell 0
      logic [TIME_W-1:0] key;       // timestamp being inserted
   } cell_ctrl_type;

   // Replace the digits below the kept prefix with the fill digit.
   function automatic logic [TIME_W-1:0] fill_time(input logic [TIME_W-1:0] t,
                                                  input logic [GRAN_W-1:0] gran,
                                                  input logic [3:0]        fill);
      logic [3:0]        dropped;
      logic [TIME_W-1:0] res;
      case (gran)
         GRAN_YEAR:   dropped = 4'd10;
         GRAN_MONTH:  dropped = 4'd8;
         GRAN_DAY:    dropped = 4'd6;
         GRAN_HOUR:   dropped = 4'd4;
         GRAN_MINUTE: dropped = 4'd2;
         default:     dropped = 4'd0;
      endcase
      res = t;
      for (int i = 0; i < TIME_DIGITS; i++) begin
         if (4'(i) < dropped) begin
            res[4*i +: 4] = fill;
         end
      end
      return res;
   endfunction

endpackage

// ===== hdl/trls_req_if.sv =====
// Request channel: command, id, timestamps and granularity with valid/ready.
interface trls_req_if;
   import trls_pkg::*;

   logic              valid;
   logic              ready;
   logic              cmd;
   logic [LOG_ID_W-1:0] log_id;
   logic [TIME_W-1:0] time_a;
   logic [TIME_W-1:0] time_b;
   logic [GRAN_W-1:0] granularity;

   modport source (output valid, cmd, log_id, time_a, time_b, granularity,
                   input ready);
   modport sink   (input valid, cmd, log_id, time_a, time_b, granularity,
                   output ready);
endinterface

// ===== hdl/trls_rsp_if.sv =====
// Response channel: matching id, status and last flag with valid/ready.
interface trls_rsp_if;
   import trls_pkg::*;

   logic                valid;
   logic                ready;
   logic [LOG_ID_W-1:0] result_id;
   logic                id_valid;
   logic [STATUS_W-1:0] status;
   logic                last;

   modport source (output valid, result_id, id_valid, status, last, input ready);
   modport sink   (input valid, result_id, id_valid, status, last, output ready);
endinterface

// ===== hdl/trls_cell.sv =====
// One cell of the sorted chain: holds one entry, shifts right on insert, rotates left on a scan.
module trls_cell #(
   parameter int IDX   = 0,
   parameter int ID_W  = 16,
   parameter int CNT_W = 7
) (
   input  logic                          clock,
   input  trls_pkg::cell_ctrl_type       ctrl,
   input  logic [CNT_W-1:0]              count,
   input  logic [ID_W-1:0]               new_id,
   input  logic [trls_pkg::TIME_W-1:0]   prev_time,
   input  logic [ID_W-1:0]               prev_id,
   input  logic                          prev_gt,
   input  logic [trls_pkg::TIME_W-1:0]   next_time,
   input  logic [ID_W-1:0]               next_id,
   input  logic [trls_pkg::TIME_W-1:0]   head_time,
   input  logic [ID_W-1:0]               head_id,
   output logic [trls_pkg::TIME_W-1:0]   time_q,
   output logic [ID_W-1:0]               id_q,
   output logic                          gt
);
   import trls_pkg::*;

   localparam logic [CNT_W-1:0] MY_POS  = CNT_W'(IDX);
   localparam logic [CNT_W-1:0] NXT_POS = CNT_W'(IDX + 1);

   logic [TIME_W-1:0] time_ff, time_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              occ;
   logic              first_free;

   assign occ        = MY_POS < count;
   assign first_free = MY_POS == count;
   // Entry is strictly later than the key: it moves up one place
   assign gt         = occ && (time_ff > ctrl.key);

   // Insert shifts later entries right; rotate pulls from the neighbor
   always_comb begin
      time_in = time_ff;
      id_in   = id_ff;
      if (ctrl.ins && (gt || first_free)) begin
         if (prev_gt) begin
            time_in = prev_time;
            id_in   = prev_id;
         end else begin
            time_in = ctrl.key;
            id_in   = new_id;
         end
      end else if (ctrl.rot) begin
         if (NXT_POS < count) begin
            time_in = next_time;
            id_in   = next_id;
         end else if (NXT_POS == count) begin
            time_in = head_time;
            id_in   = head_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      id_ff   <= id_in;
   end

   assign time_q = time_ff;
   assign id_q   = id_ff;

endmodule

// ===== hdl/timestamp_range_log_store_unit.sv =====
// Put: status result registered the cycle after acceptance.
// Retrieve: the chain rotates one entry past cell 0 per cycle unless a match waits on a stalled rsp;
// each matching id is emitted as the next match is found.
// One request at a time; a put is taken as soon as the output register frees.
// Reset (synchronous) empties the table and idles the controller; entry
// contents are not cleared and are never read before being written.
module timestamp_range_log_store_unit #(
   parameter int TABLE_DEPTH = 64,
   parameter int ID_BITS     = 16
) (
   input  logic       clock,
   input  logic       reset,
   trls_req_if.sink   req_chan,
   trls_rsp_if.source rsp_chan
);
   import trls_pkg::*;

   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FLUSH} state_type;

   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    scan_ff, scan_in;
   logic [TIME_W-1:0]   lo_ff, lo_in;
   logic [TIME_W-1:0]   hi_ff, hi_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [ID_BITS-1:0]  pend_id_ff, pend_id_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LOG_ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic                rsp_idv_ff, rsp_idv_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   cell_ctrl_type       ctrl;
   logic                out_free;
   logic                req_ready;
   logic                accept;
   logic                head_match;
   logic                scan_done;
   logic                table_full;
   logic                put_ok;
   logic [47:0]         id_wide_in;
   logic [47:0]         pend_wide;
   logic [ID_BITS-1:0]  put_id;

   logic [TIME_W-1:0]   cell_time [TABLE_DEPTH];
   logic [ID_BITS-1:0]  cell_id   [TABLE_DEPTH];
   logic                cell_gt   [TABLE_DEPTH];

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_chan.valid && req_ready;
   assign table_full = count_ff == FULL_COUNT;
   assign put_ok     = accept && (req_chan.cmd == CMD_PUT) && !table_full;
   assign head_match = (cell_time[0] >= lo_ff) && (cell_time[0] <= hi_ff);
   assign scan_done  = scan_ff == count_ff;
   assign id_wide_in = 48'(req_chan.log_id);
   assign put_id     = id_wide_in[ID_BITS-1:0];
   assign pend_wide  = 48'(pend_id_ff);

   assign ctrl.ins = put_ok;
   assign ctrl.rot = (state_ff == ST_SCAN) && !scan_done &&
                     !(head_match && pend_valid_ff && !out_free);
   assign ctrl.key = req_chan.time_a;

   // Sorted chain of entry cells
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      logic [TIME_W-1:0]  p_time, n_time;
      logic [ID_BITS-1:0] p_id, n_id;
      logic               p_gt;
      if (i == 0) begin : g_first
         assign p_time = '0;
         assign p_id   = '0;
         assign p_gt   = 1'b0;
      end else begin : g_mid
         assign p_time = cell_time[i-1];
         assign p_id   = cell_id[i-1];
         assign p_gt   = cell_gt[i-1];
      end
      if (i == TABLE_DEPTH - 1) begin : g_end
         assign n_time = '0;
         assign n_id   = '0;
      end else begin : g_inner
         assign n_time = cell_time[i+1];
         assign n_id   = cell_id[i+1];
      end
      trls_cell #(
         .IDX   (i),
         .ID_W  (ID_BITS),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .new_id    (put_id),
         .prev_time (p_time),
         .prev_id   (p_id),
         .prev_gt   (p_gt),
         .next_time (n_time),
         .next_id   (n_id),
         .head_time (cell_time[0]),
         .head_id   (cell_id[0]),
         .time_q    (cell_time[i]),
         .id_q      (cell_id[i]),
         .gt        (cell_gt[i])
      );
   end

   // Controller next state
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      scan_in       = scan_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_idv_in    = rsp_idv_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_chan.cmd == CMD_PUT) begin
                  rsp_valid_in  = 1'b1;
                  rsp_id_in     = '0;
                  rsp_idv_in    = 1'b0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = table_full ? STATUS_FULL : STATUS_STORED;
                  if (!table_full) begin
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  lo_in         = fill_time(req_chan.time_a, req_chan.granularity, FILL_LOW);
                  hi_in         = fill_time(req_chan.time_b, req_chan.granularity, FILL_HIGH);
                  scan_in       = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_FLUSH;
            end else if (ctrl.rot) begin
               scan_in = scan_ff + 1'b1;
               if (head_match) begin
                  // Previous match is not the last: send it on
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_id_in     = pend_wide[LOG_ID_W-1:0];
                     rsp_idv_in    = 1'b1;
                     rsp_status_in = STATUS_RANGE;
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_id_in    = cell_id[0];
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_id_in     = pend_valid_ff ? pend_wide[LOG_ID_W-1:0] : '0;
               rsp_idv_in    = pend_valid_ff;
               rsp_status_in = STATUS_RANGE;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      pend_id_ff    <= pend_id_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_idv_ff    <= rsp_idv_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_chan.ready     = req_ready;
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.result_id = rsp_id_ff;
   assign rsp_chan.id_valid  = rsp_idv_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count above table depth");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff <= count_ff)
      else $error("scan position past entry count");

   a_put_count: assert property (@(posedge clock) disable iff (reset)
      put_ok |=> count_ff == $past(count_ff) + 1'b1)
      else $error("stored put did not grow the table");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("retrieve ended without a last transfer");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && count_ff >= CNT_W'(2)) |-> cell_time[0] <= cell_time[1])
      else $error("chain head out of order");

endmodule
